@@ rtl/tsas_pkg.sv @@
// ----------------------------------------------------------------------------
// tsas_pkg
// Shared types and constants of the touch sample averager: store geometry,
// datapath widths, function codes, the controller state and channel payloads.
// ----------------------------------------------------------------------------
package tsas_pkg;

	// Sample store geometry.
	localparam int STORE_DEPTH = 100;
	localparam int AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int IdxW  = $clog2(STORE_DEPTH + 1);
	localparam int CntW  = 8;

	// Datapath widths.
	localparam int RawW   = 12;
	localparam int EntryW = 2 * RawW;
	localparam int SumW   = RawW + IdxW;
	localparam int DispW  = 10;
	localparam int ProdW  = RawW + DispW;
	localparam int PixW   = 11;
	localparam int DvdW   = SumW;
	localparam int DvsW   = IdxW;
	localparam int StepW  = $clog2(DvdW + 1);

	// Full-scale raw readings of the panel.
	localparam logic [RawW-1:0] COL_FULL = 12'hEDF;
	localparam logic [RawW-1:0] ROW_FULL = 12'hFFF;

	// Reciprocals of the full-scale readings, rounded up from 2^(ProdW+RawW).
	// For any product below 2^ProdW the bits of product * reciprocal from
	// RecipShift upward are exactly the truncated quotient.
	localparam int RecipW     = ProdW + 1;
	localparam int RecipShift = ProdW + RawW;
	localparam int ScaleW     = ProdW + RecipW;
	localparam logic [RecipW-1:0] COL_RECIP = 23'd4512706;
	localparam logic [RecipW-1:0] ROW_RECIP = 23'd4195329;

	// Configuration port.
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = DispW;
	localparam logic [CfgIdxW-1:0] CFG_DISPLAY_COLUMNS = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_DISPLAY_ROWS    = 1'b1;
	localparam logic [DispW-1:0]   DISPLAY_COLUMNS_RST = 10'd240;
	localparam logic [DispW-1:0]   DISPLAY_ROWS_RST    = 10'd320;

	// Request function codes.
	localparam logic [1:0] FUNC_RESET = 2'd0;
	localparam logic [1:0] FUNC_GET   = 2'd1;
	localparam logic [1:0] FUNC_POLL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV1,
		ST_MUL,
		ST_SCALE,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] raw_col_word;
		logic [15:0] raw_row_word;
	} tsas_req_t;

	typedef struct packed {
		logic            ok;
		logic            coord_valid;
		logic [PixW-1:0] pixel_col;
		logic [PixW-1:0] pixel_row;
	} tsas_rsp_t;

endpackage

@@ rtl/tsas_if.sv @@
// ----------------------------------------------------------------------------
// tsas_if
// Valid/ready channels of the touch sample averager: requests in, results out.
// ----------------------------------------------------------------------------
interface tsas_req_if;
	import tsas_pkg::*;

	logic      valid;
	logic      ready;
	tsas_req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tsas_rsp_if;
	import tsas_pkg::*;

	logic      valid;
	logic      ready;
	tsas_rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/tsas_ram.sv @@
// ----------------------------------------------------------------------------
// tsas_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tsas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/touch_sample_average_scale.sv @@
// ----------------------------------------------------------------------------
// touch_sample_average_scale
// Averages touch-panel samples from a ring store and scales them to pixels.
// ----------------------------------------------------------------------------
// Requests arrive on req_ch, one result per request leaves on rsp_ch. A poll
// request writes the 12-bit column and row (bits 14..3 of each word) into the
// sample RAM and counts it; a reset request clears the count; a get request
// averages the stored samples, scales them by the display size and clears the
// count. The display size is set through the cfg_we/cfg_index/cfg_data port;
// the user must write it only while the block is idle; the block does not enforce it.
// The block works on one request at a time. For poll, reset, failing get and
// unknown requests the result is held in a result register and moved to the
// output register from ST_RESP; only then can a new request be taken. A get
// with n samples (n at most STORE_DEPTH) makes one RAM read per sample
// through the single read port, runs a bit-serial restoring division of
// SumW steps for the average, then a multiply by the display size and a
// reciprocal multiply for the scaling, before it reaches ST_RESP.
// Results sit in an output register; the next request is accepted while a
// result waits there, and a finished result waits in the controller until
// the output register frees up. Reset clears the count, the controller and
// the output register, and restores the display size to 240 by 320. The RAM
// contents are not cleared: a get only reads slots written since the count
// last left zero.
// ----------------------------------------------------------------------------
module touch_sample_average_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tsas_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tsas_pkg::CfgDataW-1:0] cfg_data,
	tsas_req_if.sink                      req_ch,
	tsas_rsp_if.source                    rsp_ch
);
	import tsas_pkg::*;

	state_t state_q, state_d;

	logic [DispW-1:0]  disp_cols_q, disp_rows_q;
	logic [CntW-1:0]   cnt_q;
	logic [AddrW-1:0]  wp_q;
	logic [IdxW-1:0]   n_q;
	logic [IdxW-1:0]   rd_idx_q;
	logic              rd_vld_s1;
	logic [SumW-1:0]   sum_col_q, sum_row_q;
	logic [StepW-1:0]  step_q;
	logic [DvdW-1:0]   dvd_q [2];
	logic [DvsW-1:0]   rem_q [2];
	logic [DvsW-1:0]   dvs_q [2];
	logic [DvdW-1:0]   dvd_nx [2];
	logic [DvsW-1:0]   rem_nx [2];
	logic [ProdW-1:0]  prod_col_q, prod_row_q;
	tsas_rsp_t         res_q;
	tsas_rsp_t         out_q;
	logic              out_vld_q;

	logic              req_fire;
	logic              is_get, is_poll, is_reset;
	logic [IdxW-1:0]   n_avail;
	logic              ram_we;
	logic [EntryW-1:0] ram_wdata, ram_rdata;
	logic              rd_issue, acc_done, last_step, out_load;
	logic [ProdW-1:0]  prod_col, prod_row;
	logic [ScaleW-1:0] scl_col, scl_row;

	tsas_ram #(
		.WIDTH(EntryW),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(ram_wdata),
		.raddr(rd_idx_q[AddrW-1:0]),
		.rdata(ram_rdata)
	);

	assign req_fire = req_ch.valid && req_ch.ready;
	assign is_get   = (req_ch.data.func == FUNC_GET);
	assign is_poll  = (req_ch.data.func == FUNC_POLL);
	assign is_reset = (req_ch.data.func == FUNC_RESET);
	assign n_avail  = (cnt_q > CntW'(STORE_DEPTH)) ? IdxW'(STORE_DEPTH) : IdxW'(cnt_q);
	assign ram_wdata = {req_ch.data.raw_col_word[14:3], req_ch.data.raw_row_word[14:3]};
	assign prod_col = ProdW'(dvd_q[0][RawW-1:0]) * ProdW'(disp_cols_q);
	assign prod_row = ProdW'(dvd_q[1][RawW-1:0]) * ProdW'(disp_rows_q);
	assign scl_col  = ScaleW'(prod_col_q) * ScaleW'(COL_RECIP);
	assign scl_row  = ScaleW'(prod_row_q) * ScaleW'(ROW_RECIP);

	// One restoring division step per cycle in each lane; the quotient
	// shifts into the dividend register from the bottom.
	always_comb begin
		logic [DvsW:0] rem_sh;
		logic          ge;
		for (int l = 0; l < 2; l++) begin
			rem_sh    = {rem_q[l], dvd_q[l][DvdW-1]};
			ge        = (rem_sh >= {1'b0, dvs_q[l]});
			rem_nx[l] = ge ? DvsW'(rem_sh - {1'b0, dvs_q[l]}) : DvsW'(rem_sh);
			dvd_nx[l] = {dvd_q[l][DvdW-2:0], ge};
		end
	end

	// Controller outputs.
	always_comb begin
		req_ch.ready = (state_q == ST_IDLE);
		ram_we       = (state_q == ST_IDLE) && req_ch.valid && is_poll;
		rd_issue     = (state_q == ST_ACC) && (rd_idx_q != n_q);
		acc_done     = (state_q == ST_ACC) && (rd_idx_q == n_q) && !rd_vld_s1;
		last_step    = (step_q == StepW'(DvdW - 1));
		out_load     = (state_q == ST_RESP) && (!out_vld_q || rsp_ch.ready);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = (is_get && n_avail != '0) ? ST_ACC : ST_RESP;
				end
			end
			ST_ACC: begin
				if (acc_done) begin
					state_d = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (last_step) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			disp_cols_q <= DISPLAY_COLUMNS_RST;
			disp_rows_q <= DISPLAY_ROWS_RST;
			cnt_q       <= '0;
			wp_q        <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			step_q      <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					CFG_DISPLAY_COLUMNS: disp_cols_q <= cfg_data;
					CFG_DISPLAY_ROWS:    disp_rows_q <= cfg_data;
					default: ;
				endcase
			end

			// The write pointer follows the count modulo the store depth.
			if (req_fire) begin
				if (is_poll) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1 || wp_q == AddrW'(STORE_DEPTH - 1)) begin
						wp_q <= '0;
					end else begin
						wp_q <= wp_q + 1'b1;
					end
				end else if (is_get || is_reset) begin
					cnt_q <= '0;
					wp_q  <= '0;
				end
			end

			if (state_q == ST_IDLE) begin
				rd_idx_q  <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				if (rd_issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				rd_vld_s1 <= rd_issue;
			end

			if (acc_done || last_step) begin
				step_q <= '0;
			end else if (state_q == ST_DIV1) begin
				step_q <= step_q + 1'b1;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			n_q           <= n_avail;
			res_q.ok      <= is_poll || is_reset || (is_get && n_avail != '0);
			res_q.coord_valid <= 1'b0;
			res_q.pixel_col   <= '0;
			res_q.pixel_row   <= '0;
		end

		if (state_q == ST_IDLE) begin
			sum_col_q <= '0;
			sum_row_q <= '0;
		end else if (state_q == ST_ACC && rd_vld_s1) begin
			sum_col_q <= sum_col_q + SumW'(ram_rdata[EntryW-1:RawW]);
			sum_row_q <= sum_row_q + SumW'(ram_rdata[RawW-1:0]);
		end

		case (state_q)
			ST_ACC: begin
				if (acc_done) begin
					dvd_q[0] <= DvdW'(sum_col_q);
					dvd_q[1] <= DvdW'(sum_row_q);
					rem_q[0] <= '0;
					rem_q[1] <= '0;
					dvs_q[0] <= DvsW'(n_q);
					dvs_q[1] <= DvsW'(n_q);
				end
			end
			ST_DIV1: begin
				for (int l = 0; l < 2; l++) begin
					dvd_q[l] <= dvd_nx[l];
					rem_q[l] <= rem_nx[l];
				end
			end
			ST_MUL: begin
				prod_col_q <= prod_col;
				prod_row_q <= prod_row;
			end
			ST_SCALE: begin
				res_q.ok          <= 1'b1;
				res_q.coord_valid <= 1'b1;
				res_q.pixel_col   <= scl_col[RecipShift +: PixW];
				res_q.pixel_row   <= scl_row[RecipShift +: PixW];
			end
			default: ;
		endcase

		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp_ch.valid = out_vld_q;
	assign rsp_ch.data  = out_q;
endmodule

@@ sim/touch_sample_average_scale_tb.sv @@
// ----------------------------------------------------------------------------
// touch_sample_average_scale_tb
// Drives poll, get, reset and unknown requests into the touch averager under
// several display sizes and checks every result against a predictor of the
// sample store, the count and the scaled averages, with random gaps and
// stalls on both channels.
// ----------------------------------------------------------------------------
module touch_sample_average_scale_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsas_pkg::*;

	localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	tsas_req_if req_ch();
	tsas_rsp_if rsp_ch();

	touch_sample_average_scale dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_ch    (req_ch),
		.rsp_ch    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: display size, sample count and the ring of samples.
	logic [DispW-1:0]  disp_cols = DISPLAY_COLUMNS_RST;
	logic [DispW-1:0]  disp_rows = DISPLAY_ROWS_RST;
	logic [CntW-1:0]   sample_cnt = '0;
	logic [EntryW-1:0] touch_samples [STORE_DEPTH];

	tsas_req_t  touch_backlog [$];
	tsas_rsp_t  expected_results [$];
	tsas_rsp_t  oldest_result;
	int         failures = 0;
	int         requests_queued = 0;
	int         gap_left = 0;
	int         stall_left = 0;
	int         quiet_cycles = 0;
	bit         send_bursty = 1'b1;
	bit         take_bursty = 1'b1;
	bit         quiet = 1'b0;

	function automatic tsas_rsp_t predict_touch_result(input tsas_req_t r);
		tsas_rsp_t   res;
		int unsigned n;
		int unsigned col_sum;
		int unsigned row_sum;
		int unsigned slot;
		int          i;
		res = '0;
		case (r.func)
			FUNC_RESET: begin
				sample_cnt = '0;
				res.ok = 1'b1;
			end
			FUNC_GET: begin
				n = (sample_cnt > STORE_DEPTH) ? STORE_DEPTH : sample_cnt;
				sample_cnt = '0;
				if (n != 0) begin
					col_sum = 0;
					row_sum = 0;
					for (i = 0; i < n; i++) begin
						col_sum += touch_samples[i][EntryW-1:RawW];
						row_sum += touch_samples[i][RawW-1:0];
					end
					col_sum /= n;
					row_sum /= n;
					res.pixel_col = PixW'((col_sum * disp_cols) / int'(COL_FULL));
					res.pixel_row = PixW'((row_sum * disp_rows) / int'(ROW_FULL));
					res.ok = 1'b1;
					res.coord_valid = 1'b1;
				end
			end
			FUNC_POLL: begin
				slot = sample_cnt % STORE_DEPTH;
				touch_samples[slot] = {r.raw_col_word[14:3], r.raw_row_word[14:3]};
				sample_cnt = sample_cnt + 1'b1;
				res.ok = 1'b1;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	// Sender side: presents queued requests and predicts each one it hands over.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(predict_touch_result(req_ch.data));
				if ($urandom_range(0, 49) == 0)
					send_bursty = !send_bursty;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (touch_backlog.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else if (!quiet && send_bursty && $urandom_range(0, 99) < 15) begin
					gap_left = $urandom_range(0, 8);
					req_ch.valid <= 1'b0;
				end else begin
					req_ch.data  <= touch_backlog.pop_front();
					req_ch.valid <= 1'b1;
				end
			end
		end
	end

	// Receiver side: stalls at random and checks each result against the oldest
	// expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: ok %0d coord_valid %0d",
						rsp_ch.data.ok, rsp_ch.data.coord_valid);
					failures++;
				end else begin
					oldest_result = expected_results.pop_front();
					check_field("ok", oldest_result.ok, rsp_ch.data.ok);
					check_field("coord_valid", oldest_result.coord_valid,
						rsp_ch.data.coord_valid);
					check_field("pixel_col", oldest_result.pixel_col, rsp_ch.data.pixel_col);
					check_field("pixel_row", oldest_result.pixel_row, rsp_ch.data.pixel_row);
				end
				if ($urandom_range(0, 49) == 0)
					take_bursty = !take_bursty;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet && take_bursty && $urandom_range(0, 99) < 15) begin
				stall_left = $urandom_range(0, 8);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic push_req(input logic [1:0] func, input logic [15:0] col_word,
			input logic [15:0] row_word);
		tsas_req_t r;
		r.func = func;
		r.raw_col_word = col_word;
		r.raw_row_word = row_word;
		touch_backlog.push_back(r);
		requests_queued++;
	endtask

	// A controller word with the raw reading in bits 14..3 and junk around it.
	function automatic logic [15:0] controller_word();
		logic [RawW-1:0] raw;
		case ($urandom_range(0, 7))
			0: raw = '0;
			1: raw = '1;
			2: raw = COL_FULL;
			default: raw = RawW'($urandom_range(0, 4095));
		endcase
		return {1'($urandom), raw, 3'($urandom)};
	endfunction

	task automatic wait_idle();
		while (touch_backlog.size() != 0 || req_ch.valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_display(input logic [DispW-1:0] cols, input logic [DispW-1:0] rows);
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DISPLAY_COLUMNS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_index <= CFG_DISPLAY_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_we <= 1'b0;
		disp_cols = cols;
		disp_rows = rows;
	endtask

	// Mostly touch sessions (a run of polls closed by a get), with empty gets,
	// sessions cut short by a reset, count wraparound and stray requests mixed in.
	task automatic queue_touch_sessions(input int budget);
		int target;
		int kind;
		int polls;
		int i;
		target = requests_queued + budget;
		while (requests_queued < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 6) begin
				push_req(2'($urandom_range(0, 3)), controller_word(), controller_word());
			end else begin
				if (kind < 66)
					polls = $urandom_range(1, 8);
				else if (kind < 86)
					polls = $urandom_range(9, 120);
				else if (kind < 90)
					polls = $urandom_range(250, 262);
				else
					polls = 0;
				// Keep the last session inside the budget.
				if (polls > target - requests_queued)
					polls = target - requests_queued;
				if ($urandom_range(0, 5) == 0)
					push_req(FUNC_RESET, controller_word(), controller_word());
				for (i = 0; i < polls; i++) begin
					if ($urandom_range(0, 29) == 0)
						push_req(FUNC_UNKNOWN, controller_word(), controller_word());
					push_req(FUNC_POLL, controller_word(), controller_word());
				end
				if ($urandom_range(0, 9) == 0)
					push_req(FUNC_RESET, controller_word(), controller_word());
				else
					push_req(FUNC_GET, controller_word(), controller_word());
			end
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset display size.
		push_req(FUNC_GET, 16'h0000, 16'h0000);
		push_req(FUNC_UNKNOWN, 16'hFFFF, 16'hFFFF);
		push_req(FUNC_POLL, 16'h0000, 16'hFFFF);
		push_req(FUNC_POLL, 16'hFFFF, 16'h0000);
		push_req(FUNC_POLL, 16'h7FF8, 16'h7FF8);
		push_req(FUNC_POLL, 16'h8007, 16'h8007);
		push_req(FUNC_GET, 16'h1234, 16'h5678);
		push_req(FUNC_GET, 16'h0000, 16'h0000);
		push_req(FUNC_POLL, 16'h7FF8, 16'h7FF8);
		push_req(FUNC_RESET, 16'hFFFF, 16'h0000);
		push_req(FUNC_GET, 16'h0000, 16'h0000);
		push_req(FUNC_POLL, 16'hA5A5, 16'h5A5A);
		push_req(FUNC_UNKNOWN, 16'h0000, 16'h0000);
		push_req(FUNC_GET, 16'h0000, 16'h0000);

		// Largest display: full-scale readings give the largest pixel values.
		set_display(10'd1023, 10'd1023);
		push_req(FUNC_POLL, 16'hFFFF, 16'hFFFF);
		push_req(FUNC_POLL, 16'h7FF8, 16'h7FF8);
		push_req(FUNC_GET, 16'h0000, 16'h0000);
		queue_touch_sessions(200);

		set_display(10'd1, 10'd1);
		queue_touch_sessions(120);

		set_display(10'd0, 10'd1023);
		queue_touch_sessions(60);

		set_display(DispW'($urandom_range(1, 1023)), DispW'($urandom_range(1, 1023)));
		queue_touch_sessions(280);

		// The last stretch runs with no gaps and no stalls.
		set_display(DispW'($urandom_range(1, 1023)), DispW'($urandom_range(1, 1023)));
		quiet = 1'b1;
		queue_touch_sessions(180);

		wait_idle();
		repeat (END_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			failures++;
		end
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
